>>> sv/lbps_pkg.sv
package lbps_pkg;

   localparam int NUM_LEDS_DEFAULT = 4;
   localparam int LEVEL_W          = 4;
   localparam int TICK_W           = 6;
   localparam int REPEAT_W         = 8;
   localparam int REPEAT_FOREVER_BIT = 7;

   typedef enum logic [2:0] {
      OP_TICK           = 3'd0,
      OP_SET_MODE       = 3'd1,
      OP_SET_IF_CHANGED = 3'd2,
      OP_SET_FINAL      = 3'd3,
      OP_STEADY         = 3'd4
   } lbps_op_type;

   typedef enum logic [2:0] {
      MODE_OFF    = 3'd0,
      MODE_ON     = 3'd1,
      MODE_SLOW   = 3'd2,
      MODE_FLASH  = 3'd3,
      MODE_DOUBLE = 3'd4,
      MODE_QUICK  = 3'd5
   } lbps_mode_type;

   localparam logic [TICK_W-1:0] SLOW_ON        = 6'd21;
   localparam logic [TICK_W-1:0] SLOW_PERIOD    = 6'd24;
   localparam logic [TICK_W-1:0] FLASH_ON       = 6'd9;
   localparam logic [TICK_W-1:0] FLASH_PERIOD   = 6'd12;
   localparam logic [TICK_W-1:0] DOUBLE_ON      = 6'd5;
   localparam logic [TICK_W-1:0] DOUBLE_GAP_END = 6'd8;
   localparam logic [TICK_W-1:0] DOUBLE_OFF     = 6'd13;
   localparam logic [TICK_W-1:0] DOUBLE_PERIOD  = 6'd32;
   localparam logic [TICK_W-1:0] QUICK_ON       = 6'd5;
   localparam logic [TICK_W-1:0] QUICK_PERIOD   = 6'd8;

   typedef struct packed {
      logic [2:0]          op;
      logic [2:0]          mode;
      logic [REPEAT_W-1:0] repeat_count;
      logic                final_on;
   } lbps_cmd_type;

endpackage

>>> sv/led_blink_pattern_sequencer_top.sv
// LED blink pattern sequencer, one pattern engine per LED.
// req channel: one beat per command. tuser carries the operation (tick,
// set mode, set mode if changed, set mode with final level, steady level);
// tdata carries led_index, mode, repeat_count and final_on.
// rsp channel: one beat per command with the LED levels after that command
// (led_levels, bit set when lit) and the active-low pin drive (pin_levels).
// A command is registered on acceptance and applied when it advances: a tick
// to every LED, a set operation to the LED it indexes. Its result is loaded
// into the output register as it is applied, and the rsp beat is valid from it.
// Throughput is one command per cycle while rsp_tready is high; the input and
// output registers let a new beat be taken while a result waits.
// When rsp_tready is low the result holds, one more command sits in the
// input register, and req_tready then falls until the result is taken.
// Reset puts every LED in mode off, unlit, with zero tick and repeat counts,
// and empties both registers.
module led_blink_pattern_sequencer_top #(
   parameter int NUM_LEDS = lbps_pkg::NUM_LEDS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // led_index[1:0], mode[4:2], repeat_count[12:5], final_on[13]
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // led_levels[3:0], pin_levels[7:4]
);
   import lbps_pkg::*;

   logic         s1_valid_ff, s1_valid_in;
   lbps_cmd_type s1_cmd_ff, s1_cmd_in;
   logic [1:0]   s1_idx_ff, s1_idx_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [7:0]   rsp_data_ff, rsp_data_in;

   logic                advance;
   logic                req_beat;
   logic [NUM_LEDS-1:0] sel;
   logic [NUM_LEDS-1:0] lit_next;
   logic [LEVEL_W-1:0]  levels;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_cmd_in   = s1_cmd_ff;
      s1_idx_in   = s1_idx_ff;
      if (req_beat) begin
         s1_valid_in           = 1'b1;
         s1_cmd_in.op          = req_tuser;
         s1_cmd_in.mode        = req_tdata[4:2];
         s1_cmd_in.repeat_count = req_tdata[12:5];
         s1_cmd_in.final_on    = req_tdata[13];
         s1_idx_in             = req_tdata[1:0];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   for (genvar g = 0; g < NUM_LEDS; g++) begin : g_led
      assign sel[g] = (int'(s1_idx_ff) == g);
      lbps_led_unit u_led (
         .clock    (clock),
         .reset    (reset),
         .go       (advance),
         .hit      (sel[g]),
         .cmd      (s1_cmd_ff),
         .lit_next (lit_next[g])
      );
   end

   for (genvar b = 0; b < LEVEL_W; b++) begin : g_level
      if (b < NUM_LEDS) begin : g_present
         assign levels[b] = lit_next[b];
      end else begin : g_absent
         assign levels[b] = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {~levels, levels};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cmd_ff   <= s1_cmd_in;
      s1_idx_ff   <= s1_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> sv/lbps_led_unit.sv
module lbps_led_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  go,
   input  logic                  hit,
   input  lbps_pkg::lbps_cmd_type cmd,
   output logic                  lit_next
);
   import lbps_pkg::*;

   logic [2:0]          mode_ff, mode_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;
   logic [REPEAT_W-1:0] rep_ff, rep_in;
   logic                final_ff, final_in;
   logic                lit_ff, lit_in;

   logic [TICK_W-1:0]   t;
   logic [TICK_W-1:0]   period;
   logic [REPEAT_W-1:0] rep_dec;
   logic                on;
   logic                pattern;
   logic                steady_on;

   always_comb begin
      mode_in   = mode_ff;
      tick_in   = tick_ff;
      rep_in    = rep_ff;
      final_in  = final_ff;
      lit_in    = lit_ff;
      t         = tick_ff + 1'b1;
      period    = '0;
      on        = 1'b0;
      pattern   = 1'b0;
      rep_dec   = rep_ff - 1'b1;
      steady_on = (cmd.mode != 3'(MODE_OFF));
      if (go) begin
         if (lbps_op_type'(cmd.op) == OP_TICK) begin
            tick_in = t;
            unique case (lbps_mode_type'(mode_ff))
               MODE_OFF:    lit_in = 1'b0;
               MODE_ON:     lit_in = 1'b1;
               MODE_SLOW: begin
                  on = (t < SLOW_ON);  period = SLOW_PERIOD;  pattern = 1'b1;
               end
               MODE_FLASH: begin
                  on = (t < FLASH_ON); period = FLASH_PERIOD; pattern = 1'b1;
               end
               MODE_DOUBLE: begin
                  on = (t < DOUBLE_ON) || ((t > DOUBLE_GAP_END) && (t < DOUBLE_OFF));
                  period = DOUBLE_PERIOD; pattern = 1'b1;
               end
               MODE_QUICK: begin
                  on = (t < QUICK_ON); period = QUICK_PERIOD; pattern = 1'b1;
               end
               default: ;
            endcase
            if (pattern) begin
               lit_in = on;
               if (t >= period) begin
                  tick_in = '0;
                  if (!rep_ff[REPEAT_FOREVER_BIT]) begin
                     rep_in = rep_dec;
                     if (rep_dec == '0) begin
                        mode_in  = final_ff ? 3'(MODE_ON) : 3'(MODE_OFF);
                        final_in = on;
                     end
                  end
               end
            end
         end else if (hit) begin
            unique case (lbps_op_type'(cmd.op))
               OP_SET_MODE: begin
                  mode_in = cmd.mode; tick_in = '0; rep_in = cmd.repeat_count;
                  final_in = lit_ff;
               end
               OP_SET_IF_CHANGED: begin
                  if (mode_ff != cmd.mode) begin
                     mode_in = cmd.mode; tick_in = '0; rep_in = cmd.repeat_count;
                     final_in = lit_ff;
                  end
               end
               OP_SET_FINAL: begin
                  mode_in = cmd.mode; tick_in = '0; rep_in = cmd.repeat_count;
                  final_in = cmd.final_on;
               end
               OP_STEADY: begin
                  mode_in  = steady_on ? 3'(MODE_ON) : 3'(MODE_OFF);
                  tick_in  = '0;
                  rep_in   = '0;
                  final_in = steady_on;
                  lit_in   = steady_on;
               end
               default: ;
            endcase
         end
      end
   end

   assign lit_next = lit_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= '0;
         tick_ff  <= '0;
         rep_ff   <= '0;
         final_ff <= 1'b0;
         lit_ff   <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         tick_ff  <= tick_in;
         rep_ff   <= rep_in;
         final_ff <= final_in;
         lit_ff   <= lit_in;
      end
   end

endmodule
